[src/spq_pkg.sv]
// spq_pkg: shared types and constants for the sorted priority queue with drain
// used by spq_cell and sorted_priority_queue_drain; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CLASS_W = 3;
  localparam int DUR_W   = 16;
  localparam int TOTAL_W = 20;
  localparam logic [CLASS_W-1:0] STOP_RESET = 3'd6;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DRAIN  = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [DUR_W-1:0]   dur;
  } entry_t;

  // per-cycle command broadcast along the cell chain
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t new_entry;
  } ctl_t;

  typedef struct packed {
    logic               mode;
    logic [CLASS_W-1:0] new_class;
    logic [DUR_W-1:0]   new_duration;
  } cmd_t;

  typedef struct packed {
    logic               status;
    logic [TOTAL_W-1:0] total_duration;
    logic [CNT_W-1:0]   removed_count;
    logic [CNT_W-1:0]   remaining_count;
    logic               halted_on_stop;
  } result_t;

endpackage

`default_nettype wire

[src/spq_cell.sv]
// spq_cell: one storage cell of the sorted queue chain
// depends on spq_pkg (entry_t, ctl_t)
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
  input  wire logic            clk,
  input  wire spq_pkg::ctl_t   ctl,
  input  wire logic            occ,
  input  wire logic            left_keep,
  input  wire spq_pkg::entry_t left,
  input  wire spq_pkg::entry_t right,
  output spq_pkg::entry_t      ent,
  output logic                 keep
);

  // on an insert, occupied cells with class not above the new one stay in place
  assign keep = occ && (ent.cls <= ctl.new_entry.cls);

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      ent <= right;
    end else if (ctl.ins && !keep) begin
      if (left_keep) begin
        ent <= ctl.new_entry;
      end else begin
        ent <= left;
      end
    end
  end

endmodule

`default_nettype wire

[src/sorted_priority_queue_drain.sv]
// sorted_priority_queue_drain: sorted insertion queue built as a chain of cells
// depends on spq_pkg and spq_cell
//
//   channel   signals                          transfer when
//   command   start, busy, cmd                 start && !busy
//   result    done, result                     done (one cycle, no backpressure)
//   config    cfg_valid, cfg_ready, cfg_data   cfg_valid && cfg_ready
//
// an insert completes at the transfer edge: the whole chain shifts right of the
// insertion point, and done follows in the next cycle.
// a drain pops one head entry per cycle through the chain; busy stays high
// while it pops, and done rises in the same cycle that busy falls.
// reset is synchronous: queue empty, stop class 6. results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_drain (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire spq_pkg::cmd_t               cmd,
  output logic                             done,
  output spq_pkg::result_t                 result,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [spq_pkg::CLASS_W-1:0] cfg_data
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic                          state;
  logic [spq_pkg::CNT_W-1:0]     count;
  logic [spq_pkg::CLASS_W-1:0]   stop_class;
  logic [spq_pkg::TOTAL_W-1:0]   total;
  logic [spq_pkg::CNT_W-1:0]     removed;

  spq_pkg::ctl_t   ctl;
  spq_pkg::entry_t ents  [spq_pkg::DEPTH];
  logic            keeps [spq_pkg::DEPTH];
  logic            occs  [spq_pkg::DEPTH];

  logic accept;
  logic full;
  logic pop;
  logic drain_end;

  assign busy      = (state == S_DRAIN);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign full      = (count == spq_pkg::CNT_W'(spq_pkg::DEPTH));
  assign pop       = (state == S_DRAIN) && (count != '0) && (ents[0].cls != stop_class);
  assign drain_end = (state == S_DRAIN) && !pop;

  always_comb begin
    ctl.ins           = accept && (cmd.mode == spq_pkg::MODE_INSERT) && !full;
    ctl.pop           = pop;
    ctl.new_entry.cls = cmd.new_class;
    ctl.new_entry.dur = cmd.new_duration;
  end

  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    assign occs[i] = (count > spq_pkg::CNT_W'(i));
    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (occs[i]),
        .left_keep (1'b1),
        .left      (ctl.new_entry),
        .right     (ents[i+1]),
        .ent       (ents[i]),
        .keep      (keeps[i])
      );
    end else if (i == spq_pkg::DEPTH - 1) begin : g_tail
      spq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (occs[i]),
        .left_keep (keeps[i-1]),
        .left      (ents[i-1]),
        .right     (ents[i]),
        .ent       (ents[i]),
        .keep      (keeps[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (occs[i]),
        .left_keep (keeps[i-1]),
        .left      (ents[i-1]),
        .right     (ents[i+1]),
        .ent       (ents[i]),
        .keep      (keeps[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      stop_class <= spq_pkg::STOP_RESET;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        stop_class <= cfg_data;
      end
      if (ctl.ins) begin
        count <= count + spq_pkg::CNT_W'(1);
      end else if (pop) begin
        count <= count - spq_pkg::CNT_W'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (cmd.mode == spq_pkg::MODE_DRAIN)) begin
            state <= S_DRAIN;
          end else if (accept) begin
            done <= 1'b1;
          end
        end
        S_DRAIN: begin
          if (drain_end) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // accumulators and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      total   <= '0;
      removed <= '0;
    end else if (pop) begin
      total   <= total + spq_pkg::TOTAL_W'(ents[0].dur);
      removed <= removed + spq_pkg::CNT_W'(1);
    end
    if (accept && (cmd.mode == spq_pkg::MODE_INSERT)) begin
      result.status          <= full ? spq_pkg::STATUS_FULL : spq_pkg::STATUS_DONE;
      result.total_duration  <= '0;
      result.removed_count   <= '0;
      result.remaining_count <= full ? count : count + spq_pkg::CNT_W'(1);
      result.halted_on_stop  <= 1'b0;
    end else if (drain_end) begin
      result.status          <= spq_pkg::STATUS_DONE;
      result.total_duration  <= total;
      result.removed_count   <= removed;
      result.remaining_count <= count;
      result.halted_on_stop  <= (count != '0);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
    else $error("queue count above depth");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe while draining");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    pop |=> (count == $past(count) - spq_pkg::CNT_W'(1)))
    else $error("pop did not decrement count");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> (count == $past(count) + spq_pkg::CNT_W'(1)))
    else $error("insert did not increment count");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= spq_pkg::CNT_W'(2)) |-> (ents[0].cls <= ents[1].cls))
    else $error("head entries out of order");

endmodule

`default_nettype wire
